/* sv/empu_pkg.sv */
// ----------------------------------------------------------------------------
// empu_pkg
// Shared types and constants for the edge matrix preconditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package empu_pkg;

    localparam int MAX_EDGE_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 20;
    localparam int FRAC_BITS       = 16;
    localparam int EDGE_REG_BITS   = 5;
    localparam logic [EDGE_REG_BITS-1:0] EDGE_RESET = 5'd16;

    // configuration register indexes
    localparam logic CFG_INVERSE   = 1'b0;
    localparam logic CFG_EDGE_SIZE = 1'b1;

    // input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WR    = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_PASS  = 7'b0100000,
        S_ERR   = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_LEFT = 2'd1,
        K_PASS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SEL_MAC  = 2'd0,
        SEL_PASS = 2'd1,
        SEL_ERR  = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     coef_we;
        logic     capture;
        logic     wr;
        logic     issue;
        logic     setup_right;
        logic     next_row;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic  err;
        t_kind kind;
        logic  last;
        logic  k_last;
        logic  row_last;
        logic  right;
        logic  mac_busy;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/empu_ctrl.sv */
// ----------------------------------------------------------------------------
// empu_ctrl
// Sequencer: sample bookkeeping, edge multiply-accumulate rows, result emit.
// ----------------------------------------------------------------------------
`default_nettype none

module empu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_command,
    input  wire empu_pkg::t_sts i_sts,
    output empu_pkg::t_cmd     o_cmd,
    output logic               o_busy
);

    empu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= empu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != empu_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = empu_pkg::SEL_MAC;
        unique case (r_state)
            empu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == empu_pkg::CMD_SAMPLE) begin
                        o_cmd.capture = 1'b1;
                        n_state = empu_pkg::S_WR;
                    end else begin
                        o_cmd.coef_we = 1'b1;
                    end
                end
            end
            empu_pkg::S_WR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.err) begin
                    n_state = empu_pkg::S_ERR;
                end else begin
                    case (i_sts.kind)
                        empu_pkg::K_LEFT: n_state = empu_pkg::S_MAC;
                        empu_pkg::K_PASS: n_state = empu_pkg::S_PASS;
                        default:          n_state = empu_pkg::S_IDLE;
                    endcase
                end
            end
            empu_pkg::S_MAC: begin
                o_cmd.issue = 1'b1;
                if (i_sts.k_last) begin
                    n_state = empu_pkg::S_DRAIN;
                end
            end
            empu_pkg::S_DRAIN: begin
                if (!i_sts.mac_busy) begin
                    n_state = empu_pkg::S_EMIT;
                end
            end
            empu_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = empu_pkg::SEL_MAC;
                    if (i_sts.right) begin
                        if (i_sts.row_last) begin
                            n_state = empu_pkg::S_IDLE;
                        end else begin
                            o_cmd.next_row = 1'b1;
                            n_state = empu_pkg::S_MAC;
                        end
                    end else if (i_sts.last) begin
                        o_cmd.setup_right = 1'b1;
                        n_state = empu_pkg::S_MAC;
                    end else begin
                        n_state = empu_pkg::S_IDLE;
                    end
                end
            end
            empu_pkg::S_PASS: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = empu_pkg::SEL_PASS;
                    if (i_sts.last) begin
                        o_cmd.setup_right = 1'b1;
                        n_state = empu_pkg::S_MAC;
                    end else begin
                        n_state = empu_pkg::S_IDLE;
                    end
                end
            end
            empu_pkg::S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = empu_pkg::SEL_ERR;
                    n_state = empu_pkg::S_IDLE;
                end
            end
            default: n_state = empu_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/empu_datapath.sv */
// ----------------------------------------------------------------------------
// empu_datapath
// Coefficient, head and tail stores, pipelined MAC, rounding and output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module empu_datapath #(
    parameter int MAX_EDGE    = empu_pkg::MAX_EDGE_DEF,
    parameter int SAMPLE_BITS = empu_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = empu_pkg::COEF_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire empu_pkg::t_cmd                i_cmd,
    output empu_pkg::t_sts                     o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [empu_pkg::EDGE_REG_BITS-1:0] i_cfg_data,
    input  wire logic [1:0]                    i_coef_bank,
    input  wire logic [3:0]                    i_coef_row,
    input  wire logic [3:0]                    i_coef_col,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_value,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_sample_last,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic                               o_out_last,
    output logic                               o_length_error
);

    localparam int E_W    = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
    localparam int N_W    = $clog2(MAX_EDGE + 1);
    localparam int PC_W   = $clog2(2 * MAX_EDGE + 1);
    localparam int CA_W   = $clog2(4 * MAX_EDGE * MAX_EDGE);
    localparam int CDEPTH = 4 * MAX_EDGE * MAX_EDGE;
    localparam int P_W    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = P_W + E_W + 1;
    localparam int Q_W    = ACC_W + 1;
    localparam int FB     = empu_pkg::FRAC_BITS;
    localparam int RW     = empu_pkg::EDGE_REG_BITS;

    // config
    logic          r_inv;
    logic [RW-1:0] r_edge;

    // sample bookkeeping
    logic [PC_W-1:0] r_pos;
    logic [E_W-1:0]  r_ptr, r_base;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic            r_last;

    // mac control
    logic [E_W-1:0]  r_k, r_c, r_slot;
    logic            r_right;
    logic            r_v1, r_v2;

    // stores
    logic signed [COEF_BITS-1:0]   r_coef_mem [CDEPTH];
    logic signed [SAMPLE_BITS-1:0] r_head_mem [MAX_EDGE];
    logic signed [SAMPLE_BITS-1:0] r_ring_mem [MAX_EDGE];
    logic signed [COEF_BITS-1:0]   r_coef_q;
    logic signed [SAMPLE_BITS-1:0] r_head_q, r_ring_q;
    logic signed [P_W-1:0]         r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic [N_W-1:0]  w_n;
    logic [PC_W-1:0] w_n2, w_i, w_i1;
    logic [E_W-1:0]  w_effptr, w_nextptr, w_ring_addr, w_slot_nx;
    logic            w_err;
    empu_pkg::t_kind w_kind;
    logic            w_coef_ok;
    logic [CA_W-1:0] w_waddr, w_raddr;
    logic            w_ring_rd;

    logic [ACC_W-1:0] w_mag;
    logic [Q_W-1:0]   w_rnd;
    logic signed [SAMPLE_BITS-1:0] w_fin;
    logic [Q_W-1:0]   w_hi, w_lo_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= 1'b0;
            r_edge <= empu_pkg::EDGE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == empu_pkg::CFG_INVERSE) begin
                r_inv <= i_cfg_data[0];
            end else begin
                r_edge <= i_cfg_data;
            end
        end
    end

    // effective edge size, clamped into 1..MAX_EDGE
    always_comb begin
        if (r_edge == '0) begin
            w_n = N_W'(1);
        end else if (32'(r_edge) > MAX_EDGE) begin
            w_n = N_W'(MAX_EDGE);
        end else begin
            w_n = N_W'(r_edge);
        end
    end

    assign w_n2  = PC_W'(w_n) << 1;
    assign w_i   = (r_pos > w_n2) ? w_n2 : r_pos;
    assign w_i1  = w_i + PC_W'(1);
    assign w_err = r_last && (w_i1 < w_n2);

    always_comb begin
        if (w_i < PC_W'(w_n)) begin
            w_kind = empu_pkg::K_NONE;
        end else if (w_i < w_n2) begin
            w_kind = empu_pkg::K_LEFT;
        end else begin
            w_kind = empu_pkg::K_PASS;
        end
    end

    assign w_effptr  = (N_W'(r_ptr) >= w_n) ? '0 : r_ptr;
    assign w_nextptr = (N_W'(w_effptr) + N_W'(1) == w_n) ? '0 : w_effptr + E_W'(1);
    assign w_slot_nx = (N_W'(r_slot) + N_W'(1) == w_n) ? '0 : r_slot + E_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ptr <= '0;
        end else if (i_cmd.wr) begin
            if (w_err || r_last) begin
                r_pos <= '0;
                r_ptr <= '0;
            end else begin
                r_pos <= (w_i1 > w_n2) ? w_n2 : w_i1;
                r_ptr <= w_nextptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
            r_last   <= i_sample_last;
        end
        if (i_cmd.wr) begin
            r_base  <= w_nextptr;
            r_c     <= E_W'(w_i - PC_W'(w_n));
            r_right <= 1'b0;
            r_k     <= '0;
        end else if (i_cmd.setup_right) begin
            r_right <= 1'b1;
            r_c     <= '0;
            r_k     <= '0;
            r_slot  <= r_base;
        end else if (i_cmd.next_row) begin
            r_c    <= r_c + E_W'(1);
            r_k    <= '0;
            r_slot <= r_base;
        end else if (i_cmd.issue) begin
            r_k    <= r_k + E_W'(1);
            r_slot <= w_slot_nx;
        end
    end

    // coefficient store
    assign w_coef_ok = (32'(i_coef_row) < MAX_EDGE) && (32'(i_coef_col) < MAX_EDGE);
    assign w_waddr = CA_W'(i_coef_bank) * CA_W'(MAX_EDGE * MAX_EDGE)
                   + CA_W'(i_coef_row) * CA_W'(MAX_EDGE) + CA_W'(i_coef_col);
    assign w_raddr = CA_W'({r_inv, r_right}) * CA_W'(MAX_EDGE * MAX_EDGE)
                   + CA_W'(r_c) * CA_W'(MAX_EDGE) + CA_W'(r_k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_we && w_coef_ok) begin
            r_coef_mem[w_waddr] <= i_coef_value;
        end
        if (i_cmd.issue) begin
            r_coef_q <= r_coef_mem[w_raddr];
        end
    end

    // head store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !w_err && w_kind == empu_pkg::K_NONE) begin
            r_head_mem[w_i[E_W-1:0]] <= r_sample;
        end
        if (i_cmd.issue) begin
            r_head_q <= r_head_mem[r_k];
        end
    end

    // tail ring, read-before-write gives the displaced sample
    assign w_ring_addr = i_cmd.wr ? w_effptr : r_slot;
    assign w_ring_rd   = (i_cmd.wr && !w_err) || i_cmd.issue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !w_err) begin
            r_ring_mem[w_effptr] <= r_sample;
        end
        if (w_ring_rd) begin
            r_ring_q <= r_ring_mem[w_ring_addr];
        end
    end

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= (r_right ? r_ring_q : r_head_q) * r_coef_q;
        end
        if (i_cmd.wr || i_cmd.setup_right || i_cmd.next_row) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round to nearest, ties away from zero, then saturate
    assign w_mag    = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign w_rnd    = ({1'b0, w_mag} + (Q_W'(1) << (FB - 1))) >> FB;
    assign w_hi     = (Q_W'(1) << (SAMPLE_BITS - 1)) - Q_W'(1);
    assign w_lo_mag = Q_W'(1) << (SAMPLE_BITS - 1);

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            if (w_rnd > w_lo_mag) begin
                w_fin = SAMPLE_BITS'(w_lo_mag);
            end else begin
                w_fin = SAMPLE_BITS'(~w_rnd + Q_W'(1));
            end
        end else if (w_rnd > w_hi) begin
            w_fin = SAMPLE_BITS'(w_hi);
        end else begin
            w_fin = SAMPLE_BITS'(w_rnd);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                empu_pkg::SEL_PASS: begin
                    o_out_sample   <= r_ring_q;
                    o_out_last     <= 1'b0;
                    o_length_error <= 1'b0;
                end
                empu_pkg::SEL_ERR: begin
                    o_out_sample   <= '0;
                    o_out_last     <= 1'b1;
                    o_length_error <= 1'b1;
                end
                default: begin
                    o_out_sample   <= w_fin;
                    o_out_last     <= r_right && (N_W'(r_c) + N_W'(1) == w_n);
                    o_length_error <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.err      = w_err;
        o_sts.kind     = w_kind;
        o_sts.last     = r_last;
        o_sts.k_last   = (N_W'(r_k) + N_W'(1) == w_n);
        o_sts.row_last = (N_W'(r_c) + N_W'(1) == w_n);
        o_sts.right    = r_right;
        o_sts.mac_busy = r_v1 || r_v2;
        o_sts.out_free = !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

/* sv/edge_matrix_preconditioner_unit.sv */
// ----------------------------------------------------------------------------
// edge_matrix_preconditioner_unit
// Replaces the first and last N samples of a signal by edge matrix products.
// ----------------------------------------------------------------------------
// Input channel (valid/stall): command 0 loads one coefficient into bank,
// row, col; command 1 delivers a sample. Output channel (valid/stall)
// returns preconditioned samples in signal order, N behind. One sample is
// processed at a time. A sample with no result is only written, an interior
// one is written and emitted, a left edge one runs N multiply-accumulates,
// one per cycle through a single multiplier reading one coefficient-store
// word per cycle, then drains the pipeline and is emitted. The final sample
// adds N rows for the right edge. A signal ending before 2N samples yields
// one result with length_error. Config writes (index 0 inverse, 1 edge_size)
// are always ready; the user must make them while the block is idle, which
// the block does not enforce. Reset clears position, ring pointer and
// config; coefficient and sample stores are undefined until written.
// A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_matrix_preconditioner_unit #(
    parameter int MAX_EDGE    = empu_pkg::MAX_EDGE_DEF,
    parameter int SAMPLE_BITS = empu_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = empu_pkg::COEF_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [empu_pkg::EDGE_REG_BITS-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_command,
    input  wire logic [1:0]                    i_coef_bank,
    input  wire logic [3:0]                    i_coef_row,
    input  wire logic [3:0]                    i_coef_col,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_value,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_sample_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic                               o_out_last,
    output logic                               o_length_error
);

    empu_pkg::t_cmd w_cmd;
    empu_pkg::t_sts w_sts;
    logic           w_busy;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;

    empu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    empu_datapath #(
        .MAX_EDGE    (MAX_EDGE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_coef_bank    (i_coef_bank),
        .i_coef_row     (i_coef_row),
        .i_coef_col     (i_coef_col),
        .i_coef_value   (i_coef_value),
        .i_sample       (i_sample),
        .i_sample_last  (i_sample_last),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_sample   (o_out_sample),
        .o_out_last     (o_out_last),
        .o_length_error (o_length_error)
    );

    // an error transaction always closes the signal and carries no sample
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> o_out_last && (o_out_sample == '0))
        else $error("length error result malformed");

    // result register is empty right after reset
    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // a new sample transaction is followed by a busy sequencer
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command |=> o_in_stall)
        else $error("sequencer idle after sample transaction");

endmodule

`default_nettype wire
